/* rtl/mls_pkg.sv */
// Shared codes, constants and link types for the lattice oscillator sweep block
`default_nettype none
package mls_pkg;
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_PROPOSE = 2'd1;
	localparam logic [1:0] MODE_ACCEPT  = 2'd2;

	localparam logic [1:0] KIND_VERDICT = 2'd0;
	localparam logic [1:0] KIND_ACTION  = 2'd1;
	localparam logic [1:0] KIND_CORR    = 2'd2;

	localparam logic [1:0] CFG_STEP  = 2'd0;
	localparam logic [1:0] CFG_MASS  = 2'd1;
	localparam logic [1:0] CFG_OMEGA = 2'd2;
	localparam logic [1:0] CFG_GAP   = 2'd3;

	localparam logic [23:0] STEP_RST  = 24'd32768;
	localparam logic [23:0] MASS_RST  = 24'd65536;
	localparam logic [23:0] OMEGA_RST = 24'd65536;
	localparam logic [15:0] GAP_RST   = 16'd10;

	localparam int MAX_CORR = 32;

	localparam logic [61:0] ACT_SAT  = 62'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] VAL_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;
	localparam logic [24:0] HALF_Q24 = 25'd8388608;

	typedef struct packed {
		logic        vld;
		logic        first;
		logic [31:0] x;
	} mls_feed_t;

	typedef struct packed {
		logic        done;
		logic        measure;
		logic [31:0] ln;
	} mls_math_t;
endpackage
`default_nettype wire

/* rtl/metropolis_lattice_oscillator_sweep.sv */
// Top level: position memories, sweep sequencer, configuration and result register
// Load item: a single write. Proposal item: read, then write back of the same site.
// Acceptance item: two action walks through the position memory and a decision state
// that waits for the log and remainder units, plus a restore walk on rejection.
// Results: verdict, then action and NC correlators (each read, multiplied, emitted) when
// the sweep is measured. Reset: async, clears control, counters and the per-site valid
// and touched flags; no clearing pass, unwritten positions read as zero.
`default_nettype none
module metropolis_lattice_oscillator_sweep #(
	parameter int SITES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [23:0]        uniform,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              kind,
	output logic [4:0]              site,
	output logic signed [47:0]      value,
	output logic                    accepted,
	output logic [31:0]             rejections,
	output logic [31:0]             sweep_index,
	output logic                    last
);
	import mls_pkg::*;

	localparam int AW  = $clog2(SITES);
	localparam int RCW = $clog2(SITES + 2);
	localparam int NC  = (SITES < MAX_CORR) ? SITES : MAX_CORR;
	localparam int CW  = $clog2(NC);
	localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_PROP    = 12'b0000_0000_0010,
		ST_PRE1    = 12'b0000_0000_0100,
		ST_PRE2    = 12'b0000_0000_1000,
		ST_WALK    = 12'b0000_0001_0000,
		ST_DECIDE  = 12'b0000_0010_0000,
		ST_RESTORE = 12'b0000_0100_0000,
		ST_VERDICT = 12'b0000_1000_0000,
		ST_ACTION  = 12'b0001_0000_0000,
		ST_CRD     = 12'b0010_0000_0000,
		ST_CMUL    = 12'b0100_0000_0000,
		ST_CEMIT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [31:0] pos_mem [SITES];
	logic [31:0] sv_mem  [SITES];
	logic [31:0] pos_rd, sv_rd;
	logic [AW-1:0] rd_addr;
	logic          pos_we, sv_we;
	logic [AW-1:0] pos_wa;
	logic [31:0]   pos_wd;

	logic [23:0] step_q, mass_q, omega_q;
	logic [15:0] gap_q;
	logic [AW-1:0] ptr_q;
	logic [SITES-1:0] touched_q, pvld_q;
	logic [31:0] sweep_q, rej_q, idx_q;
	logic [23:0] u_q;
	logic signed [49:0] prop_q;
	logic [AW-1:0] raddr_q;
	logic          rvalid_q, rfirst_q;
	logic [RCW-1:0] rc_q, rcm1;
	logic          pass_q;
	logic [61:0]   h1_q, h2_q;
	logic [31:0]   w2_q;
	logic [39:0]   mw2_q;
	logic          acc_q, meas_q;
	logic [47:0]   mval_q;
	logic [CW-1:0] ci_q;
	logic [31:0]   x0_q;
	logic signed [63:0] cprod_q;

	logic          out_valid_q;
	logic          out_free;
	logic          item_acc;
	logic          walk_issue, rest_issue;
	logic [31:0]   rd_x, walk_x;
	logic signed [24:0] du;
	logic signed [34:0] nx;
	logic [31:0]   nx_sat;
	logic signed [63:0] drop, lnx;
	logic          accn;
	logic [61:0]   s_meas;
	logic [47:0]   w2_full;
	logic [55:0]   mw2_full;
	logic          act_clr;
	logic [61:0]   act_sum;
	logic          act_done;
	mls_feed_t     feed;
	mls_math_t     math;
	logic          math_start;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign math_start = item_acc && (mode == MODE_ACCEPT);

	assign rcm1       = rc_q - RCW'(1);
	assign walk_issue = (state_q == ST_WALK) && (rc_q <= RCW'(SITES));
	assign rest_issue = (state_q == ST_RESTORE) && (rc_q < RCW'(SITES));

	always_comb begin
		case (state_q)
			ST_WALK:    rd_addr = (rc_q == '0) ? LAST_SITE : rcm1[AW-1:0];
			ST_RESTORE: rd_addr = rc_q[AW-1:0];
			ST_CRD:     rd_addr = AW'(ci_q);
			default:    rd_addr = ptr_q;
		endcase
	end

	assign rd_x   = pvld_q[raddr_q] ? pos_rd : 32'd0;
	assign walk_x = (!pass_q && touched_q[raddr_q]) ? sv_rd : rd_x;

	assign du     = $signed({1'b0, uniform}) - $signed(HALF_Q24);
	assign nx     = 35'($signed(rd_x)) + 35'($signed(prop_q[49:16]));
	always_comb begin
		if (nx > 35'sh0_7FFF_FFFF) begin
			nx_sat = 32'h7FFF_FFFF;
		end else if (nx < -35'sh0_8000_0000) begin
			nx_sat = 32'h8000_0000;
		end else begin
			nx_sat = nx[31:0];
		end
	end

	always_comb begin
		pos_we = 1'b0;
		pos_wa = raddr_q;
		pos_wd = sv_rd;
		sv_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pos_we = item_acc && (mode == MODE_LOAD);
				pos_wa = ptr_q;
				pos_wd = {8'b0, uniform};
			end
			ST_PROP: begin
				pos_we = 1'b1;
				pos_wd = nx_sat;
				sv_we  = !touched_q[raddr_q];
			end
			ST_RESTORE: begin
				pos_we = rvalid_q && touched_q[raddr_q];
			end
			default: begin
				pos_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		pos_rd <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sv_we) begin
			sv_mem[raddr_q] <= rd_x;
		end
		sv_rd <= sv_mem[rd_addr];
	end

	assign drop   = $signed({2'b0, h1_q}) - $signed({2'b0, h2_q});
	assign lnx    = 64'($signed(math.ln));
	assign accn   = (u_q == 24'd0) || !(lnx > drop);
	assign s_meas = accn ? h2_q : h1_q;
	assign w2_full  = 48'(omega_q) * 48'(omega_q);
	assign mw2_full = 56'(mass_q) * 56'(w2_q);

	assign feed.vld   = rvalid_q && (state_q == ST_WALK);
	assign feed.first = rfirst_q;
	assign feed.x     = walk_x;

	assign act_clr = (state_q == ST_PRE2) || ((state_q == ST_WALK) && act_done && !pass_q);

	mls_action #(.SITES(SITES)) u_action (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (act_clr),
		.feed   (feed),
		.mass   (mass_q),
		.mw2    (mw2_q),
		.sum    (act_sum),
		.done   (act_done)
	);

	mls_math u_math (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (math_start),
		.uniform (uniform),
		.gap     (gap_q),
		.idx     (sweep_q),
		.res     (math)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_RST;
			mass_q      <= MASS_RST;
			omega_q     <= OMEGA_RST;
			gap_q       <= GAP_RST;
			ptr_q       <= '0;
			touched_q   <= '0;
			pvld_q      <= '0;
			sweep_q     <= '0;
			rej_q       <= '0;
			rvalid_q    <= 1'b0;
			rfirst_q    <= 1'b0;
			rc_q        <= '0;
			pass_q      <= 1'b0;
			ci_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP:  step_q  <= cfg_data;
					CFG_MASS:  mass_q  <= cfg_data;
					CFG_OMEGA: omega_q <= cfg_data;
					CFG_GAP:   gap_q   <= cfg_data[15:0];
					default:   gap_q   <= gap_q;
				endcase
			end
			rvalid_q <= walk_issue || rest_issue;
			rfirst_q <= walk_issue && (rc_q == '0);
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						case (mode)
							MODE_LOAD: begin
								pvld_q[ptr_q] <= 1'b1;
								ptr_q <= (ptr_q == LAST_SITE) ? '0 : ptr_q + AW'(1);
							end
							MODE_PROPOSE: begin
								ptr_q   <= (ptr_q == LAST_SITE) ? '0 : ptr_q + AW'(1);
								state_q <= ST_PROP;
							end
							MODE_ACCEPT: begin
								state_q <= ST_PRE1;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_PROP: begin
					pvld_q[raddr_q]    <= 1'b1;
					touched_q[raddr_q] <= 1'b1;
					state_q            <= ST_IDLE;
				end
				ST_PRE1: begin
					state_q <= ST_PRE2;
				end
				ST_PRE2: begin
					rc_q    <= '0;
					pass_q  <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_issue) begin
						rc_q <= rc_q + RCW'(1);
					end
					if (act_done) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
							rc_q   <= '0;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (math.done) begin
						sweep_q <= sweep_q + 32'd1;
						if (!accn && rej_q != 32'hFFFF_FFFF) begin
							rej_q <= rej_q + 32'd1;
						end
						rc_q    <= '0;
						state_q <= accn ? ST_VERDICT : ST_RESTORE;
					end
				end
				ST_RESTORE: begin
					if (rest_issue) begin
						rc_q <= rc_q + RCW'(1);
					end else if (!rvalid_q) begin
						state_q <= ST_VERDICT;
					end
				end
				ST_VERDICT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						touched_q   <= '0;
						ptr_q       <= '0;
						ci_q        <= '0;
						state_q     <= meas_q ? ST_ACTION : ST_IDLE;
					end
				end
				ST_ACTION: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_CRD;
					end
				end
				ST_CRD: begin
					state_q <= ST_CMUL;
				end
				ST_CMUL: begin
					state_q <= ST_CEMIT;
				end
				ST_CEMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (ci_q == CW'(NC - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							ci_q    <= ci_q + CW'(1);
							state_q <= ST_CRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raddr_q <= rd_addr;
		if (item_acc) begin
			u_q    <= uniform;
			idx_q  <= sweep_q;
			prop_q <= du * $signed({1'b0, step_q});
		end
		if (state_q == ST_PRE1) begin
			w2_q <= w2_full[47:16];
		end
		if (state_q == ST_PRE2) begin
			mw2_q <= mw2_full[55:16];
		end
		if (state_q == ST_WALK && act_done) begin
			if (!pass_q) begin
				h1_q <= act_sum;
			end else begin
				h2_q <= act_sum;
			end
		end
		if (state_q == ST_DECIDE && math.done) begin
			acc_q  <= accn;
			meas_q <= math.measure;
			mval_q <= (s_meas[61:47] != '0) ? VAL_MAX : {1'b0, s_meas[46:0]};
		end
		if (state_q == ST_CMUL) begin
			if (ci_q == '0) begin
				x0_q    <= rd_x;
				cprod_q <= $signed(rd_x) * $signed(rd_x);
			end else begin
				cprod_q <= $signed(x0_q) * $signed(rd_x);
			end
		end
		if (state_q == ST_VERDICT && out_free) begin
			kind        <= KIND_VERDICT;
			site        <= '0;
			value       <= '0;
			accepted    <= acc_q;
			rejections  <= rej_q;
			sweep_index <= idx_q;
			last        <= !meas_q;
		end
		if (state_q == ST_ACTION && out_free) begin
			kind  <= KIND_ACTION;
			site  <= '0;
			value <= $signed(mval_q);
			last  <= 1'b0;
		end
		if (state_q == ST_CEMIT && out_free) begin
			kind  <= KIND_CORR;
			site  <= 5'(ci_q);
			value <= 48'($signed(cprod_q[63:24]));
			last  <= (ci_q == CW'(NC - 1));
		end
	end

	assign result_valid = out_valid_q;
endmodule
`default_nettype wire

/* rtl/mls_math.sv */
// Iterative log unit for the draw and sweep-index remainder unit for the measure gap
`default_nettype none
module mls_math (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [23:0]      uniform,
	input  wire logic [15:0]      gap,
	input  wire logic [31:0]      idx,
	output mls_pkg::mls_math_t    res
);
	import mls_pkg::*;

	logic [4:0]  e_c;
	logic [30:0] z_init;
	logic [4:0]  e_q;
	logic [30:0] z_q;
	logic [23:0] frac_q;
	logic [4:0]  l_cnt_q;
	logic        l_run_q, l_mul_q, l_done_q;
	logic [61:0] sq;
	logic [31:0] zn;
	logic [6:0]  em24;
	logic signed [30:0] l2;
	logic signed [63:0] ln_prod;
	logic signed [63:0] ln_q;

	logic [15:0] gap_q, rem_q;
	logic [31:0] dv_q;
	logic [4:0]  m_cnt_q;
	logic        m_run_q;
	logic [16:0] t;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < 24; i++) begin
			if (uniform[i]) begin
				e_c = 5'(i);
			end
		end
		z_init = {7'b0, uniform} << (5'd30 - e_c);
	end

	assign sq      = 62'(z_q) * 62'(z_q);
	assign zn      = sq[61:30];
	assign em24    = {2'b0, e_q} - 7'd24;
	assign l2      = $signed({em24, frac_q});
	assign ln_prod = 64'(l2) * $signed({32'b0, LN2_Q32});
	assign t       = {rem_q, dv_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_run_q  <= 1'b0;
			l_mul_q  <= 1'b0;
			l_done_q <= 1'b0;
			m_run_q  <= 1'b0;
		end else if (start) begin
			l_run_q  <= 1'b1;
			l_mul_q  <= 1'b0;
			l_done_q <= 1'b0;
			m_run_q  <= 1'b1;
		end else begin
			if (l_run_q && l_cnt_q == 5'd23) begin
				l_run_q <= 1'b0;
				l_mul_q <= 1'b1;
			end
			if (l_mul_q) begin
				l_mul_q  <= 1'b0;
				l_done_q <= 1'b1;
			end
			if (m_run_q && m_cnt_q == 5'd31) begin
				m_run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			e_q     <= e_c;
			z_q     <= z_init;
			frac_q  <= '0;
			l_cnt_q <= '0;
			gap_q   <= (gap == 16'd0) ? 16'd1 : gap;
			rem_q   <= '0;
			dv_q    <= idx;
			m_cnt_q <= '0;
		end else begin
			if (l_run_q) begin
				l_cnt_q <= l_cnt_q + 5'd1;
				if (zn[31]) begin
					z_q    <= zn[31:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					z_q    <= zn[30:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			if (l_mul_q) begin
				ln_q <= ln_prod;
			end
			if (m_run_q) begin
				m_cnt_q <= m_cnt_q + 5'd1;
				dv_q    <= {dv_q[30:0], 1'b0};
				if (t >= {1'b0, gap_q}) begin
					rem_q <= 16'(t - {1'b0, gap_q});
				end else begin
					rem_q <= t[15:0];
				end
			end
		end
	end

	assign res.done    = l_done_q && !m_run_q && !start;
	assign res.measure = (rem_q == 16'd0);
	assign res.ln      = ln_q[63:32];
endmodule
`default_nettype wire

/* rtl/mls_action.sv */
// Pipelined action accumulator: kinetic and potential terms per site, saturating sum
`default_nettype none
module mls_action #(
	parameter int SITES = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clr,
	input  wire mls_pkg::mls_feed_t feed,
	input  wire logic [23:0]       mass,
	input  wire logic [39:0]       mw2,
	output logic [61:0]            sum,
	output logic                   done
);
	import mls_pkg::*;

	localparam int NW = $clog2(SITES + 1);

	logic [31:0] prev_q;
	logic signed [32:0] diff;
	logic [32:0] ax_w;
	logic [32:0] ad_w;
	logic [31:0] ad_s1, ax_s1;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [63:0] sq_d, sq_x;
	logic [39:0] d2_s2, x2_s2;
	logic [63:0] kin_s3;
	logic [59:0] pl_s3, ph_s3;
	logic [79:0] pot_full;
	logic [62:0] term_s4;
	logic [63:0] sum_n;
	logic [61:0] sum_q;
	logic [NW-1:0] cnt_q;

	assign diff = $signed({feed.x[31], feed.x}) - $signed({prev_q[31], prev_q});
	assign ad_w = diff[32] ? 33'(-diff) : 33'(diff);
	assign ax_w = feed.x[31] ? 33'(-$signed({1'b1, feed.x})) : {1'b0, feed.x};
	assign sq_d = 64'(ad_s1) * 64'(ad_s1);
	assign sq_x = 64'(ax_s1) * 64'(ax_s1);
	assign pot_full = {ph_s3, 20'b0} + 80'(pl_s3);
	assign sum_n = {2'b0, sum_q} + {1'b0, term_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			cnt_q <= '0;
			sum_q <= '0;
		end else begin
			v_s1 <= feed.vld && !feed.first;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (clr) begin
				cnt_q <= '0;
				sum_q <= '0;
			end else if (v_s4) begin
				cnt_q <= cnt_q + NW'(1);
				sum_q <= (sum_n > {2'b0, ACT_SAT}) ? ACT_SAT : sum_n[61:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.vld) begin
			prev_q <= feed.x;
		end
		ad_s1   <= ad_w[31:0];
		ax_s1   <= ax_w[31:0];
		d2_s2   <= sq_d[63:24];
		x2_s2   <= sq_x[63:24];
		kin_s3  <= 64'(d2_s2) * 64'(mass);
		pl_s3   <= 60'(x2_s2) * 60'(mw2[19:0]);
		ph_s3   <= 60'(x2_s2) * 60'(mw2[39:20]);
		term_s4 <= {16'b0, kin_s3[63:17]} + pot_full[79:17];
	end

	assign sum  = sum_q;
	assign done = (cnt_q == NW'(SITES));
endmodule
`default_nettype wire

/* rtl/mls_checker.sv */
// Port-level checker for the lattice oscillator sweep block, bound to the top level
`default_nettype none
module mls_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [1:0]         kind,
	input wire logic [4:0]         site,
	input wire logic signed [47:0] value,
	input wire logic               accepted,
	input wire logic [31:0]        rejections,
	input wire logic               last
);
	import mls_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(value) && $stable(kind) && $stable(last))
		else $error("stalled result changed");

	a_verdict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_VERDICT |-> site == 5'd0 && value == 48'sd0)
		else $error("verdict carries site or value");

	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !accepted |-> rejections != 32'd0)
		else $error("rejected sweep with zero rejection count");

	a_action_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ACTION |-> !value[47] && !last)
		else $error("action result negative or marked last");
endmodule

bind metropolis_lattice_oscillator_sweep mls_checker u_mls_checker (.*);
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the lattice oscillator Metropolis sweep block
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import mls_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [4:0]  site;
		logic [47:0] value;
		logic        accepted;
		logic [31:0] rejections;
		logic [31:0] sweep_index;
		logic        last;
	} result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [23:0] u;
		int          want_acc;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [1:0] mode;
	logic [23:0] uniform;
	logic result_valid;
	logic result_stall;
	logic [1:0] kind;
	logic [4:0] site;
	logic signed [47:0] value;
	logic accepted;
	logic [31:0] rejections;
	logic [31:0] sweep_index;
	logic last;

	metropolis_lattice_oscillator_sweep dut (.*);

	// predictor state
	logic [23:0] m_step, m_mass, m_omega;
	logic [15:0] m_gap;
	int          lat_pos[32];
	int          lat_saved[32];
	bit          lat_touched[32];
	int unsigned lat_ptr, sweep_cnt, reject_cnt;
	result_t     expected_results[$];

	int errors, n_items, n_results, n_sweeps, n_rejects, cycles;
	int burst_left;
	bit gaps_on, hold_req;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1000000) begin
				$display("timeout after %0d cycles", cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic report(string what, longint unsigned want, longint unsigned got);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: expected %0h got %0h (result %0d)", what, want, got,
				n_results);
	endtask

	function automatic logic [61:0] mul_trunc(longint unsigned a, longint unsigned b, int s);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		return (p > {66'd0, ACT_SAT}) ? ACT_SAT : p[61:0];
	endfunction

	function automatic logic [61:0] sat_sum(logic [61:0] a, logic [61:0] b);
		logic [62:0] r;
		r = a + b;
		return (r > {1'b0, ACT_SAT}) ? ACT_SAT : r[61:0];
	endfunction

	function automatic longint lat_val(int i, bit start);
		return (start && lat_touched[i]) ? lat_saved[i] : lat_pos[i];
	endfunction

	function automatic logic [61:0] path_action(bit start);
		logic [61:0] w2, mw2, sum, kin, pot;
		longint x, xp, ad, ax;
		w2 = mul_trunc(m_omega, m_omega, 16);
		mw2 = mul_trunc(m_mass, w2, 16);
		sum = 0;
		for (int i = 0; i < 32; i++) begin
			x = lat_val(i, start);
			xp = lat_val((i + 31) % 32, start);
			ad = (x > xp) ? x - xp : xp - x;
			ax = (x < 0) ? -x : x;
			kin = mul_trunc(mul_trunc(ad, ad, 24), m_mass, 17);
			pot = mul_trunc(mul_trunc(ax, ax, 24), mw2, 17);
			sum = sat_sum(sum, sat_sum(kin, pot));
		end
		return sum;
	endfunction

	function automatic longint log_draw(logic [23:0] u);
		int e;
		longint unsigned z;
		longint frac, l2;
		e = 23;
		frac = 0;
		while (e > 0 && !u[e]) e--;
		z = longint'(u) << (30 - e);
		for (int k = 0; k < 24; k++) begin
			z = (z * z) >> 30;
			frac = frac << 1;
			if (z >= (64'd2 << 30)) begin
				z = z >> 1;
				frac = frac | 1;
			end
		end
		l2 = longint'(e - 24) * (64'sd1 << 24) + frac;
		return (l2 * longint'(LN2_Q32)) >>> 32;
	endfunction

	function automatic void push_result(logic [1:0] k, int s, logic [47:0] v, bit acc,
			int unsigned idx);
		result_t r;
		r.kind = k;
		r.site = s[4:0];
		r.value = v;
		r.accepted = acc;
		r.rejections = reject_cnt;
		r.sweep_index = idx;
		r.last = 0;
		expected_results.push_back(r);
	endfunction

	// returns verdict (1 accept) for acceptance items, -1 otherwise
	function automatic int sweep_predict(logic [1:0] md, logic [23:0] u);
		longint shift, nx, drop, c;
		logic [61:0] h1, h2, s;
		bit acc;
		int unsigned idx, gap;
		if (md == MODE_LOAD) begin
			lat_pos[lat_ptr] = int'(u);
			lat_ptr = (lat_ptr + 1) % 32;
		end else if (md == MODE_PROPOSE) begin
			shift = ((longint'(u) - 64'sd8388608) * longint'(m_step)) >>> 16;
			nx = longint'(lat_pos[lat_ptr]) + shift;
			if (!lat_touched[lat_ptr]) begin
				lat_saved[lat_ptr] = lat_pos[lat_ptr];
				lat_touched[lat_ptr] = 1;
			end
			if (nx > 64'sd2147483647) nx = 64'sd2147483647;
			if (nx < -64'sd2147483648) nx = -64'sd2147483648;
			lat_pos[lat_ptr] = int'(nx);
			lat_ptr = (lat_ptr + 1) % 32;
		end else if (md == MODE_ACCEPT) begin
			h1 = path_action(1);
			h2 = path_action(0);
			drop = longint'(h1) - longint'(h2);
			acc = (u == 0) || !(log_draw(u) > drop);
			idx = sweep_cnt;
			gap = (m_gap == 0) ? 1 : m_gap;
			if (!acc) begin
				for (int i = 0; i < 32; i++)
					if (lat_touched[i]) lat_pos[i] = lat_saved[i];
				if (reject_cnt != 32'hFFFF_FFFF) reject_cnt++;
				n_rejects++;
			end
			for (int i = 0; i < 32; i++) lat_touched[i] = 0;
			lat_ptr = 0;
			sweep_cnt = idx + 1;
			n_sweeps++;
			push_result(KIND_VERDICT, 0, 0, acc, idx);
			if (idx % gap == 0) begin
				s = path_action(0);
				push_result(KIND_ACTION, 0, (s > {14'd0, VAL_MAX}) ? VAL_MAX : s[47:0],
					acc, idx);
				for (int i = 0; i < 32; i++) begin
					c = (longint'(lat_pos[0]) * longint'(lat_pos[i])) >>> 24;
					push_result(KIND_CORR, i, c[47:0], acc, idx);
				end
			end
			expected_results[$].last = 1;
			return acc;
		end
		return -1;
	endfunction

	task automatic sender_gap();
		int idle;
		if (!gaps_on) return;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			idle = $urandom_range(0, 8);
			if (idle > 0) begin
				item_valid <= 0;
				repeat (idle) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_item(logic [1:0] md, logic [23:0] u, output int verdict);
		bit took;
		@(negedge clk);
		sender_gap();
		item_valid <= 1;
		mode <= md;
		uniform <= u;
		took = 0;
		while (!took) begin
			#1;
			took = !item_stall;
			@(posedge clk);
			if (!took) @(negedge clk);
		end
		verdict = sweep_predict(md, u);
		n_items++;
	endtask

	task automatic settle();
		@(negedge clk);
		item_valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_STEP:  m_step = data;
			CFG_MASS:  m_mass = data;
			CFG_OMEGA: m_omega = data;
			CFG_GAP:   m_gap = data[15:0];
			default:   m_gap = m_gap;
		endcase
	endtask

	task automatic random_sweeps(int count);
		int v, np, sent, roll;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_item(2'd3, 24'($urandom), v);
				sent++;
			end else if (roll < 14) begin
				send_item(2'($urandom_range(0, 3)), 24'($urandom), v);
				sent++;
			end else begin
				repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0) begin
					send_item(MODE_LOAD, 24'($urandom), v);
					sent++;
				end
				np = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 45)
					: $urandom_range(1, 10);
				for (int i = 0; i < np; i++) begin
					send_item(MODE_PROPOSE, 24'($urandom), v);
					sent++;
				end
				case ($urandom_range(0, 5))
					0: send_item(MODE_ACCEPT, 24'd0, v);
					1: send_item(MODE_ACCEPT, 24'hFFFFFF, v);
					2: send_item(MODE_ACCEPT, 24'($urandom_range(1, 255)), v);
					default: send_item(MODE_ACCEPT, 24'($urandom), v);
				endcase
				sent++;
			end
		end
	endtask

	row_t directed_rows[22] = '{
		'{MODE_ACCEPT, 24'd0, 1},
		'{MODE_LOAD, 24'hFFFFFF, -1},
		'{MODE_LOAD, 24'd0, -1},
		'{MODE_LOAD, 24'h800000, -1},
		'{MODE_ACCEPT, 24'd1, 1},
		'{MODE_PROPOSE, 24'd0, -1},
		'{MODE_PROPOSE, 24'hFFFFFF, -1},
		'{MODE_PROPOSE, 24'h800000, -1},
		'{MODE_ACCEPT, 24'hFFFFFF, -1},
		'{MODE_PROPOSE, 24'h7FFFFF, -1},
		'{MODE_LOAD, 24'h123456, -1},
		'{2'd3, 24'hFFFFFF, -1},
		'{2'd3, 24'd0, -1},
		'{MODE_ACCEPT, 24'h800000, -1},
		'{MODE_PROPOSE, 24'hFFFFFF, -1},
		'{MODE_PROPOSE, 24'hFFFFFF, -1},
		'{MODE_ACCEPT, 24'hFFFFFF, -1},
		'{MODE_PROPOSE, 24'h000001, -1},
		'{MODE_ACCEPT, 24'd0, 1},
		'{MODE_PROPOSE, 24'h555555, -1},
		'{MODE_PROPOSE, 24'hAAAAAA, -1},
		'{MODE_ACCEPT, 24'h000002, -1}
	};

	// receiver: stall pattern is redrawn at random among four patterns, plus one long hold-off
	initial begin
		int pat, hold;
		result_stall = 0;
		pat = 0;
		forever begin
			@(negedge clk);
			if (cycles % 64 == 0) pat = $urandom_range(0, 3);
			if (hold_req) begin
				hold_req = 0;
				result_stall <= 1;
				hold = 600;
				while (hold > 0) begin
					@(negedge clk);
					hold--;
				end
			end
			case (pat)
				0: result_stall <= 0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 1) == 0);
				default: result_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// result checker
	initial begin
		result_t got, want;
		bit take;
		forever begin
			@(negedge clk);
			#2;
			take = result_valid && !result_stall;
			got.kind = kind;
			got.site = site;
			got.value = value;
			got.accepted = accepted;
			got.rejections = rejections;
			got.sweep_index = sweep_index;
			got.last = last;
			@(posedge clk);
			if (take) begin
				n_results++;
				if (expected_results.size() == 0) begin
					report("unexpected result", 0, got.kind);
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind) report("kind", want.kind, got.kind);
					if (got.site !== want.site) report("site", want.site, got.site);
					if (got.value !== want.value) report("value", want.value, got.value);
					if (got.accepted !== want.accepted)
						report("accepted", want.accepted, got.accepted);
					if (got.rejections !== want.rejections)
						report("rejections", want.rejections, got.rejections);
					if (got.sweep_index !== want.sweep_index)
						report("sweep_index", want.sweep_index, got.sweep_index);
					if (got.last !== want.last) report("last", want.last, got.last);
				end
			end
		end
	end

	initial begin
		int v;
		errors = 0; n_items = 0; n_results = 0; n_sweeps = 0; n_rejects = 0;
		burst_left = 0; gaps_on = 1; hold_req = 0;
		arst_n = 0;
		cfg_we = 0; cfg_index = CFG_STEP; cfg_data = 0;
		item_valid = 0; mode = MODE_LOAD; uniform = 0;
		m_step = STEP_RST; m_mass = MASS_RST; m_omega = OMEGA_RST; m_gap = GAP_RST;
		for (int i = 0; i < 32; i++) begin
			lat_pos[i] = 0;
			lat_saved[i] = 0;
			lat_touched[i] = 0;
		end
		lat_ptr = 0; sweep_cnt = 0; reject_cnt = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].mode, directed_rows[i].u, v);
			if (directed_rows[i].want_acc >= 0 && v != directed_rows[i].want_acc)
				report("directed verdict", directed_rows[i].want_acc, v);
		end
		settle();

		// extremes: widest steps, heaviest mass, measure every sweep; long hold-off
		write_reg(CFG_STEP, 24'hFFFFFF);
		write_reg(CFG_MASS, 24'hFFFFFF);
		write_reg(CFG_OMEGA, 24'hFFFFFF);
		write_reg(CFG_GAP, 24'd1);
		hold_req = 1;
		random_sweeps(100);
		settle();

		// zero coefficients, gap of zero, no sender gaps
		gaps_on = 0;
		write_reg(CFG_STEP, 24'd0);
		write_reg(CFG_MASS, 24'd0);
		write_reg(CFG_OMEGA, 24'd0);
		write_reg(CFG_GAP, 24'd0);
		random_sweeps(60);
		settle();
		gaps_on = 1;

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(CFG_STEP, 24'($urandom_range(0, 24'h0FFFFF)));
			write_reg(CFG_MASS, 24'($urandom_range(0, 24'h03FFFF)));
			write_reg(CFG_OMEGA, 24'($urandom_range(0, 24'h03FFFF)));
			write_reg(CFG_GAP, (ph == 2) ? 24'hFFFF : 24'($urandom_range(1, 4)));
			random_sweeps(85);
			settle();
		end

		if (expected_results.size() != 0)
			report("results never delivered", expected_results.size(), 0);
		$display("covered %0d items, %0d sweeps (%0d rejected), %0d results checked",
			n_items, n_sweeps, n_rejects, n_results);
		$display("settings: reset, all-max, all-zero and three random register sets");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* metropolis_lattice_oscillator_sweep.f */
rtl/mls_pkg.sv
rtl/mls_math.sv
rtl/mls_action.sv
rtl/metropolis_lattice_oscillator_sweep.sv
rtl/mls_checker.sv
sim/tb_top.sv
